// File: hdl/entry_ring_offset_lookup_assert.svh
// assertion macros for the ring lookup sequencer (erol_seq)
`ifndef ENTRY_RING_OFFSET_LOOKUP_ASSERT_SVH
`define ENTRY_RING_OFFSET_LOOKUP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define EROL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define EROL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/erol_pkg.sv
package erol_pkg;

   localparam int HANDLE_W = 32;
   localparam int LENGTH_W = 16;
   localparam int OFFSET_W = 20;

   // operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_FIND = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_POST
   } state_type;

   // sequencer to span unit
   typedef struct packed {
      logic load;
      logic step;
   } span_ctrl_type;

   // span unit to sequencer
   typedef struct packed {
      logic                hit;
      logic [LENGTH_W-1:0] byte_pos;
   } span_stat_type;

endpackage

// File: hdl/entry_ring_offset_lookup.sv
// adds: an add is written at its accepting edge, one add per cycle while idle
// finds: a find reads the stored records oldest first, one record read per cycle, through the
// registered memory read and the span compare; a hit or a walk past every record is registered,
// then loaded into the output register once it is free, and the next request is taken in the
// cycle after that word is loaded; no new request is taken while a find walks (one span unit)
// reset: synchronous, active high; ring emptied, no output word pending, memory not cleared
module entry_ring_offset_lookup #(
   parameter int RING_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [erol_pkg::HANDLE_W-1:0] req_record_handle,
   input  logic [erol_pkg::LENGTH_W-1:0] req_record_length,
   input  logic [erol_pkg::OFFSET_W-1:0] req_char_offset,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [erol_pkg::HANDLE_W-1:0] rsp_hit_handle,
   output logic [erol_pkg::LENGTH_W-1:0] rsp_hit_length,
   output logic [erol_pkg::LENGTH_W-1:0] rsp_byte_in_record
);

   localparam int IW = $clog2(RING_DEPTH);

   // memory port wires
   logic                          mem_wr_en;
   logic [IW-1:0]                 mem_wr_addr;
   logic [erol_pkg::HANDLE_W-1:0] mem_wr_handle;
   logic [erol_pkg::LENGTH_W-1:0] mem_wr_length;
   logic                          mem_rd_en;
   logic [IW-1:0]                 mem_rd_addr;
   logic [erol_pkg::HANDLE_W-1:0] mem_rd_handle;
   logic [erol_pkg::LENGTH_W-1:0] mem_rd_length;

   // span unit control and status
   erol_pkg::span_ctrl_type span_ctrl;
   erol_pkg::span_stat_type span_stat;

   // sequencer: ring pointers, walk control, output register
   erol_seq #(
      .RING_DEPTH (RING_DEPTH)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_record_handle  (req_record_handle),
      .req_record_length  (req_record_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_hit_handle     (rsp_hit_handle),
      .rsp_hit_length     (rsp_hit_length),
      .rsp_byte_in_record (rsp_byte_in_record),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_handle      (mem_wr_handle),
      .mem_wr_length      (mem_wr_length),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_handle      (mem_rd_handle),
      .mem_rd_length      (mem_rd_length),
      .span_ctrl          (span_ctrl),
      .span_stat          (span_stat)
   );

   // record store, one write and one registered read port
   erol_ring_mem #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_handle (mem_wr_handle),
      .wr_length (mem_wr_length),
      .rd_en     (mem_rd_en),
      .rd_addr   (mem_rd_addr),
      .rd_handle (mem_rd_handle),
      .rd_length (mem_rd_length)
   );

   // shared running-sum adder and offset compare
   erol_span_unit u_span_unit (
      .clock  (clock),
      .ctrl   (span_ctrl),
      .target (req_char_offset),
      .length (mem_rd_length),
      .stat   (span_stat)
   );

endmodule

// File: hdl/erol_ring_mem.sv
module erol_ring_mem #(
   parameter int RING_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(RING_DEPTH)-1:0]        wr_addr,
   input  logic [erol_pkg::HANDLE_W-1:0]        wr_handle,
   input  logic [erol_pkg::LENGTH_W-1:0]        wr_length,
   input  logic                                 rd_en,
   input  logic [$clog2(RING_DEPTH)-1:0]        rd_addr,
   output logic [erol_pkg::HANDLE_W-1:0]        rd_handle,
   output logic [erol_pkg::LENGTH_W-1:0]        rd_length
);

   logic [erol_pkg::HANDLE_W-1:0] handle_mem [RING_DEPTH];
   logic [erol_pkg::LENGTH_W-1:0] length_mem [RING_DEPTH];
   logic [erol_pkg::HANDLE_W-1:0] rd_handle_ff;
   logic [erol_pkg::LENGTH_W-1:0] rd_length_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         handle_mem[wr_addr] <= wr_handle;
         length_mem[wr_addr] <= wr_length;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_handle_ff <= handle_mem[rd_addr];
         rd_length_ff <= length_mem[rd_addr];
      end
   end

   assign rd_handle = rd_handle_ff;
   assign rd_length = rd_length_ff;

endmodule

// File: hdl/erol_span_unit.sv
module erol_span_unit (
   input  logic                          clock,
   input  erol_pkg::span_ctrl_type       ctrl,
   input  logic [erol_pkg::OFFSET_W-1:0] target,
   input  logic [erol_pkg::LENGTH_W-1:0] length,
   output erol_pkg::span_stat_type       stat
);

   logic [erol_pkg::OFFSET_W-1:0] target_ff;
   logic [erol_pkg::OFFSET_W-1:0] base_ff;
   logic [erol_pkg::OFFSET_W-1:0] base_in;
   logic [erol_pkg::OFFSET_W:0]   span_end;
   logic [erol_pkg::OFFSET_W-1:0] diff;

   // one add and compare per record: end of this record's span
   assign span_end = {1'b0, base_ff} + {{(erol_pkg::OFFSET_W + 1 - erol_pkg::LENGTH_W){1'b0}},
                                        length};
   assign diff     = target_ff - base_ff;

   assign stat.hit      = {1'b0, target_ff} < span_end;
   assign stat.byte_pos = diff[erol_pkg::LENGTH_W-1:0];

   always_comb begin
      base_in = base_ff;
      if (ctrl.load) begin
         base_in = '0;
      end else if (ctrl.step) begin
         // no hit means span_end <= target, so it fits the offset width
         base_in = span_end[erol_pkg::OFFSET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      if (ctrl.load) begin
         target_ff <= target;
      end
   end

endmodule

// File: hdl/erol_seq.sv
`include "entry_ring_offset_lookup_assert.svh"

module erol_seq #(
   parameter int RING_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [erol_pkg::HANDLE_W-1:0]        req_record_handle,
   input  logic [erol_pkg::LENGTH_W-1:0]        req_record_length,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic [erol_pkg::HANDLE_W-1:0]        rsp_hit_handle,
   output logic [erol_pkg::LENGTH_W-1:0]        rsp_hit_length,
   output logic [erol_pkg::LENGTH_W-1:0]        rsp_byte_in_record,
   output logic                                 mem_wr_en,
   output logic [$clog2(RING_DEPTH)-1:0]        mem_wr_addr,
   output logic [erol_pkg::HANDLE_W-1:0]        mem_wr_handle,
   output logic [erol_pkg::LENGTH_W-1:0]        mem_wr_length,
   output logic                                 mem_rd_en,
   output logic [$clog2(RING_DEPTH)-1:0]        mem_rd_addr,
   input  logic [erol_pkg::HANDLE_W-1:0]        mem_rd_handle,
   input  logic [erol_pkg::LENGTH_W-1:0]        mem_rd_length,
   output erol_pkg::span_ctrl_type              span_ctrl,
   input  erol_pkg::span_stat_type              span_stat
);

   localparam int IW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(RING_DEPTH);

   erol_pkg::state_type state_ff, state_in;

   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [IW-1:0] old_idx_ff, old_idx_in;
   logic          full_ff, full_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] issue_left_ff, issue_left_in;
   logic          data_valid_ff, data_valid_in;

   logic                          res_found_ff, res_found_in;
   logic [erol_pkg::HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [erol_pkg::LENGTH_W-1:0] res_length_ff, res_length_in;
   logic [erol_pkg::LENGTH_W-1:0] res_byte_ff, res_byte_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [erol_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [erol_pkg::LENGTH_W-1:0] rsp_length_ff, rsp_length_in;
   logic [erol_pkg::LENGTH_W-1:0] rsp_byte_ff, rsp_byte_in;

   logic          slot_free;
   logic [CW-1:0] stored_count;
   logic [IW-1:0] wr_idx_next;
   logic [IW-1:0] old_idx_next;
   logic [IW-1:0] rd_idx_next;

   assign wr_idx_next  = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
   assign old_idx_next = (old_idx_ff == LAST_IDX) ? '0 : old_idx_ff + 1'b1;
   assign rd_idx_next  = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;

   always_comb begin
      if (full_ff) begin
         stored_count = FULL_CNT;
      end else if (wr_idx_ff >= old_idx_ff) begin
         stored_count = CW'(wr_idx_ff) - CW'(old_idx_ff);
      end else begin
         stored_count = CW'(wr_idx_ff) + FULL_CNT - CW'(old_idx_ff);
      end
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      wr_idx_in     = wr_idx_ff;
      old_idx_in    = old_idx_ff;
      full_in       = full_ff;
      rd_idx_in     = rd_idx_ff;
      issue_left_in = issue_left_ff;
      data_valid_in = 1'b0;
      res_found_in  = res_found_ff;
      res_handle_in = res_handle_ff;
      res_length_in = res_length_ff;
      res_byte_in   = res_byte_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_length_in = rsp_length_ff;
      rsp_byte_in   = rsp_byte_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_idx_ff;
      span_ctrl     = '0;

      case (state_ff)
         erol_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_operation == erol_pkg::OP_ADD) begin
                  mem_wr_en = 1'b1;
                  if (full_ff) begin
                     old_idx_in = old_idx_next;
                  end
                  wr_idx_in = wr_idx_next;
                  full_in   = (wr_idx_next == old_idx_in);
               end else begin
                  span_ctrl.load = 1'b1;
                  rd_idx_in      = old_idx_ff;
                  issue_left_in  = stored_count;
                  state_in       = erol_pkg::S_WALK;
               end
            end
         end
         erol_pkg::S_WALK: begin
            if (data_valid_ff && span_stat.hit) begin
               res_found_in  = 1'b1;
               res_handle_in = mem_rd_handle;
               res_length_in = mem_rd_length;
               res_byte_in   = span_stat.byte_pos;
               state_in      = erol_pkg::S_POST;
            end else begin
               span_ctrl.step = data_valid_ff;
               if (issue_left_ff != '0) begin
                  mem_rd_en     = 1'b1;
                  rd_idx_in     = rd_idx_next;
                  issue_left_in = issue_left_ff - 1'b1;
                  data_valid_in = 1'b1;
               end else if (!data_valid_ff) begin
                  // every stored record passed without a hit
                  res_found_in  = 1'b0;
                  res_handle_in = '0;
                  res_length_in = '0;
                  res_byte_in   = '0;
                  state_in      = erol_pkg::S_POST;
               end
            end
         end
         erol_pkg::S_POST: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_handle_in = res_handle_ff;
               rsp_length_in = res_length_ff;
               rsp_byte_in   = res_byte_ff;
               state_in      = erol_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = erol_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= erol_pkg::S_IDLE;
         wr_idx_ff     <= '0;
         old_idx_ff    <= '0;
         full_ff       <= 1'b0;
         issue_left_ff <= '0;
         data_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_idx_ff     <= wr_idx_in;
         old_idx_ff    <= old_idx_in;
         full_ff       <= full_in;
         issue_left_ff <= issue_left_in;
         data_valid_ff <= data_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      res_found_ff  <= res_found_in;
      res_handle_ff <= res_handle_in;
      res_length_ff <= res_length_in;
      res_byte_ff   <= res_byte_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_length_ff <= rsp_length_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   assign req_stall          = (state_ff != erol_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_hit_handle     = rsp_handle_ff;
   assign rsp_hit_length     = rsp_length_ff;
   assign rsp_byte_in_record = rsp_byte_ff;
   assign mem_wr_addr        = wr_idx_ff;
   assign mem_wr_handle      = req_record_handle;
   assign mem_wr_length      = req_record_length;

   `EROL_ASSERT_NOW(a_full_means_aligned, full_ff, wr_idx_ff == old_idx_ff,
      "full ring with write and oldest index apart")
   `EROL_ASSERT_NOW(a_issue_bounded, 1'b1, issue_left_ff <= FULL_CNT,
      "walk count beyond ring depth")
   `EROL_ASSERT_NOW(a_byte_inside_hit, rsp_valid_ff && rsp_found_ff,
      rsp_byte_ff < rsp_length_ff, "byte position outside the hit record")
   `EROL_ASSERT_NOW(a_miss_is_zero, rsp_valid_ff && !rsp_found_ff,
      rsp_handle_ff == '0 && rsp_length_ff == '0 && rsp_byte_ff == '0,
      "miss word with nonzero fields")
   `EROL_ASSERT_NEXT(a_post_delivers, state_ff == erol_pkg::S_POST && slot_free,
      rsp_valid_ff && state_ff == erol_pkg::S_IDLE, "finished find not delivered")

endmodule
